// ===== hw/rtl/scs_pkg.sv =====
// Package for the segmented candidate sieve.
// Holds sizes, field widths, command codes, controller states and the
// command and status bundles. It depends on nothing else.
`default_nettype none

package scs_pkg;

  // Sieve and table sizes.
  localparam int unsigned MAX_SIEVE_BITS = 262144;
  localparam int unsigned MAX_PRIMES     = 8192;
  localparam int unsigned WORD_COUNT     = (MAX_SIEVE_BITS + 31) / 32;
  localparam int unsigned WORD_AW        = $clog2(WORD_COUNT);
  localparam int unsigned PRIME_AW       = $clog2(MAX_PRIMES);
  localparam int unsigned MIN_SEGMENT    = 32;

  // Fixed field and register widths.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SLOT_W     = 13;
  localparam int unsigned PRIME_W    = 24;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 19;
  localparam int unsigned COUNT_W    = 14;
  localparam int unsigned NWORD_W    = WORD_AW + 1;
  localparam int unsigned HIT_W      = PRIME_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 19;

  // Bit-within-word mask.
  localparam logic [4:0] BIT_MASK = 5'h1F;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMES_IN_USE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_PRIME = 2'd0,
    CMD_LOAD_BASE  = 2'd1,
    CMD_RESTART    = 2'd2,
    CMD_NEXT       = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT,
    ST_FAIL,
    ST_START,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_PRIME_CHK,
    ST_PRIME_RD,
    ST_PRIME_LD,
    ST_PRIME_TEST,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_OFF_WR,
    ST_BUILD_END
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start_build;
    logic copy_rd;
    logic copy_wr;
    logic prime_rd;
    logic prime_ld;
    logic hit_rd;
    logic hit_wr;
    logic off_wr;
    logic build_end;
    logic scan_rd;
    logic scan_chk;
    logic emit;
    logic seg_fail;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic pending;
    logic copy_last;
    logic prime_last;
    logic p_zero;
    logic j_lt_seg;
    logic scan_end;
    logic word_hit;
    logic hit_ok;
    logic out_free;
  } status_t;

  // Index of the lowest set bit of a non-zero word.
  function automatic logic [4:0] lowest_bit(input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] iso;
    logic [4:0]        idx;
    iso = w & (~w + 1'b1);
    idx = '0;
    for (int k = 0; k < DATA_W; k++) begin
      if (iso[k]) begin
        idx = idx | 5'(k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scs_in_if.sv =====
// Input channel of the segmented candidate sieve: valid, ready and command.
// Depends on scs_pkg for the field widths.
`default_nettype none

interface scs_in_if import scs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   slot;
  logic [PRIME_W-1:0]  prime_value;
  logic [PRIME_W-1:0]  first_offset;
  logic [DATA_W-1:0]   pattern_word;

  modport source (output valid, cmd, slot, prime_value, first_offset, pattern_word,
                  input ready);
  modport sink   (input valid, cmd, slot, prime_value, first_offset, pattern_word,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scs_out_if.sv =====
// Output channel of the segmented candidate sieve: valid, ready and candidate.
// Depends on scs_pkg for the field width.
`default_nettype none

interface scs_out_if import scs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] candidate;

  modport source (output valid, candidate, input ready);
  modport sink   (input valid, candidate, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Stands alone; used for every store of the sieve.
`default_nettype none

module scs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/scs_datapath.sv =====
// Datapath of the segmented candidate sieve: configuration, pointers, the four
// stores and the output register. Depends on scs_pkg and scs_ram.
`default_nettype none

module scs_datapath import scs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_t                 ctrl_i,
  output      status_t               status_o,
  input  wire logic [CMD_W-1:0]      cmd_i,
  input  wire logic [SLOT_W-1:0]     slot_i,
  input  wire logic [PRIME_W-1:0]    prime_value_i,
  input  wire logic [PRIME_W-1:0]    first_offset_i,
  input  wire logic [DATA_W-1:0]     pattern_word_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [DATA_W-1:0]     candidate_o
);

  logic [POS_W-1:0]   seg_bits_q;
  logic [COUNT_W-1:0] primes_q;
  logic [POS_W-1:0]   scan_q, scan_d;
  logic [DATA_W-1:0]  base_q, base_d;
  logic               pending_q, pending_d;
  logic [POS_W-1:0]   active_q, active_d;
  logic [POS_W-1:0]   seg_q, seg_d;
  logic [COUNT_W-1:0] nprime_q, nprime_d;
  logic [NWORD_W-1:0] nw_q, nw_d;
  logic [WORD_AW-1:0] k_q, k_d;
  logic [COUNT_W-1:0] i_q, i_d;
  logic [PRIME_W-1:0] p_q, p_d;
  logic [HIT_W-1:0]   j_q, j_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  cand_q, cand_d;

  logic [POS_W-1:0]   eff_bits;
  logic [COUNT_W-1:0] eff_primes;
  logic               load_prime, load_base;
  logic [DATA_W-1:0]  sieve_rdata, base_rdata;
  logic [PRIME_W-1:0] prime_rdata, offset_rdata;
  logic               sieve_we;
  logic [WORD_AW-1:0] sieve_waddr, sieve_raddr;
  logic [DATA_W-1:0]  sieve_wdata;
  logic               offset_we;
  logic [PRIME_AW-1:0] offset_waddr;
  logic [PRIME_W-1:0] offset_wdata;
  logic [WORD_AW-1:0] hit_word, scan_word;
  logic [DATA_W-1:0]  masked;
  logic [POS_W-1:0]   found_pos;
  logic [HIT_W-1:0]   j_left;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_bits_q <= POS_W'(MAX_SIEVE_BITS);
      primes_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEGMENT_BITS:  seg_bits_q <= cfg_data_i;
        CFG_PRIMES_IN_USE: primes_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes, saturated to their legal ranges.
  always_comb begin
    if (seg_bits_q < POS_W'(MIN_SEGMENT)) begin
      eff_bits = POS_W'(MIN_SEGMENT);
    end else if (seg_bits_q > POS_W'(MAX_SIEVE_BITS)) begin
      eff_bits = POS_W'(MAX_SIEVE_BITS);
    end else begin
      eff_bits = seg_bits_q;
    end
    if (primes_q > COUNT_W'(MAX_PRIMES)) begin
      eff_primes = COUNT_W'(MAX_PRIMES);
    end else begin
      eff_primes = primes_q;
    end
  end

  assign load_prime = ctrl_i.accept && (cmd_i == CMD_LOAD_PRIME);
  assign load_base  = ctrl_i.accept && (cmd_i == CMD_LOAD_BASE);

  // Addresses and scan arithmetic.
  assign hit_word  = j_q[WORD_AW+4:5];
  assign scan_word = scan_q[WORD_AW+4:5];
  assign masked    = sieve_rdata & ({DATA_W{1'b1}} << scan_q[4:0]);
  assign found_pos = {scan_q[POS_W-1:5], lowest_bit(masked)};
  assign j_left    = j_q - HIT_W'(seg_q);

  // Sieve store ports: copy and clear share the write port.
  always_comb begin
    sieve_we    = ctrl_i.copy_wr || ctrl_i.hit_wr;
    sieve_waddr = ctrl_i.copy_wr ? k_q : hit_word;
    sieve_wdata = ctrl_i.copy_wr ? base_rdata
                                 : (sieve_rdata & ~(DATA_W'(1) << (j_q[4:0] & BIT_MASK)));
    sieve_raddr = ctrl_i.hit_rd ? hit_word : scan_word;
  end

  // Offset store write port: loads and the end of each prime's walk.
  always_comb begin
    offset_we    = load_prime || (ctrl_i.off_wr && (p_q != '0));
    offset_waddr = load_prime ? slot_i[PRIME_AW-1:0] : i_q[PRIME_AW-1:0];
    offset_wdata = load_prime ? first_offset_i : j_left[PRIME_W-1:0];
  end

  scs_ram #(.WIDTH(DATA_W), .DEPTH(WORD_COUNT)) u_sieve (
    .clk_i, .we_i(sieve_we), .waddr_i(sieve_waddr), .wdata_i(sieve_wdata),
    .raddr_i(sieve_raddr), .rdata_o(sieve_rdata)
  );

  scs_ram #(.WIDTH(DATA_W), .DEPTH(WORD_COUNT)) u_base (
    .clk_i, .we_i(load_base), .waddr_i(slot_i[WORD_AW-1:0]), .wdata_i(pattern_word_i),
    .raddr_i(k_q), .rdata_o(base_rdata)
  );

  scs_ram #(.WIDTH(PRIME_W), .DEPTH(MAX_PRIMES)) u_prime (
    .clk_i, .we_i(load_prime), .waddr_i(slot_i[PRIME_AW-1:0]), .wdata_i(prime_value_i),
    .raddr_i(i_q[PRIME_AW-1:0]), .rdata_o(prime_rdata)
  );

  scs_ram #(.WIDTH(PRIME_W), .DEPTH(MAX_PRIMES)) u_offset (
    .clk_i, .we_i(offset_we), .waddr_i(offset_waddr), .wdata_i(offset_wdata),
    .raddr_i(i_q[PRIME_AW-1:0]), .rdata_o(offset_rdata)
  );

  // Next values of the pointers and the output register.
  always_comb begin
    scan_d      = scan_q;
    base_d      = base_q;
    pending_d   = pending_q;
    active_d    = active_q;
    seg_d       = seg_q;
    nprime_d    = nprime_q;
    nw_d        = nw_q;
    k_d         = k_q;
    i_d         = i_q;
    p_d         = p_q;
    j_d         = j_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cand_d      = cand_q;

    if (ctrl_i.accept && (cmd_i == CMD_RESTART)) begin
      base_d    = '0;
      scan_d    = '0;
      pending_d = 1'b1;
    end
    if (ctrl_i.start_build) begin
      seg_d    = eff_bits;
      nprime_d = eff_primes;
      nw_d     = NWORD_W'((eff_bits + POS_W'(31)) >> 5);
      k_d      = '0;
      i_d      = '0;
    end
    if (ctrl_i.copy_wr) begin
      k_d = k_q + 1'b1;
    end
    if (ctrl_i.prime_ld) begin
      p_d = prime_rdata;
      j_d = HIT_W'(offset_rdata);
    end
    if (ctrl_i.hit_wr) begin
      j_d = j_q + HIT_W'(p_q);
    end
    if (ctrl_i.off_wr) begin
      i_d = i_q + 1'b1;
    end
    if (ctrl_i.build_end) begin
      active_d  = seg_q;
      scan_d    = '0;
      pending_d = 1'b0;
    end
    if (ctrl_i.scan_chk) begin
      pos_d = found_pos;
      // Step to the start of the next word; the top word steps past the end.
      if (masked == '0) begin
        scan_d = {scan_q[POS_W-1:5], 5'b0} + POS_W'(32);
      end
    end
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
      cand_d      = base_q + DATA_W'(pos_q);
      scan_d      = pos_q + 1'b1;
    end
    if (ctrl_i.seg_fail) begin
      base_d    = base_q + DATA_W'(active_q);
      pending_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      base_q      <= '0;
      pending_q   <= 1'b1;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      base_q      <= base_d;
      pending_q   <= pending_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the build and the result.
  always_ff @(posedge clk_i) begin
    seg_q    <= seg_d;
    nprime_q <= nprime_d;
    nw_q     <= nw_d;
    k_q      <= k_d;
    i_q      <= i_d;
    p_q      <= p_d;
    j_q      <= j_d;
    pos_q    <= pos_d;
    cand_q   <= cand_d;
  end

  // Status towards the controller.
  always_comb begin
    status_o.cmd        = cmd_e'(cmd_i);
    status_o.pending    = pending_q;
    status_o.copy_last  = ((NWORD_W'(k_q) + 1'b1) == nw_q);
    status_o.prime_last = (i_q == nprime_q);
    status_o.p_zero     = (p_q == '0);
    status_o.j_lt_seg   = (j_q < HIT_W'(seg_q));
    status_o.scan_end   = (scan_q >= active_q);
    status_o.word_hit   = (masked != '0);
    status_o.hit_ok     = (found_pos < active_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign candidate_o = cand_q;

endmodule

`default_nettype wire

// ===== hw/rtl/scs_controller.sv =====
// Controller state machine of the segmented candidate sieve.
// Depends on scs_pkg for states and the command and status bundles.
`default_nettype none

module scs_controller import scs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output      logic    in_ready_o,
  input  wire status_t status_i,
  output      ctrl_t   ctrl_o
);

  state_e state_q, state_d;
  logic   after_build_q, after_build_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      after_build_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      after_build_q <= after_build_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    after_build_d = after_build_q;
    ctrl_o        = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
        if (in_valid_i && (status_i.cmd == CMD_NEXT)) begin
          after_build_d = status_i.pending;
          state_d       = status_i.pending ? ST_START : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (status_i.scan_end) begin
          state_d = ST_FAIL;
        end else begin
          ctrl_o.scan_rd = 1'b1;
          state_d        = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        ctrl_o.scan_chk = 1'b1;
        if (!status_i.word_hit) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = status_i.hit_ok ? ST_EMIT : ST_FAIL;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          ctrl_o.emit = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FAIL: begin
        ctrl_o.seg_fail = 1'b1;
        if (after_build_q) begin
          state_d = ST_IDLE;
        end else begin
          after_build_d = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        ctrl_o.start_build = 1'b1;
        state_d            = ST_COPY_RD;
      end
      ST_COPY_RD: begin
        ctrl_o.copy_rd = 1'b1;
        state_d        = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        ctrl_o.copy_wr = 1'b1;
        state_d        = status_i.copy_last ? ST_PRIME_CHK : ST_COPY_RD;
      end
      ST_PRIME_CHK: begin
        state_d = status_i.prime_last ? ST_BUILD_END : ST_PRIME_RD;
      end
      ST_PRIME_RD: begin
        ctrl_o.prime_rd = 1'b1;
        state_d         = ST_PRIME_LD;
      end
      ST_PRIME_LD: begin
        ctrl_o.prime_ld = 1'b1;
        state_d         = ST_PRIME_TEST;
      end
      ST_PRIME_TEST: begin
        if (!status_i.p_zero && status_i.j_lt_seg) begin
          state_d = ST_HIT_RD;
        end else begin
          state_d = ST_OFF_WR;
        end
      end
      ST_HIT_RD: begin
        ctrl_o.hit_rd = 1'b1;
        state_d       = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        ctrl_o.hit_wr = 1'b1;
        state_d       = ST_PRIME_TEST;
      end
      ST_OFF_WR: begin
        ctrl_o.off_wr = 1'b1;
        state_d       = ST_PRIME_CHK;
      end
      ST_BUILD_END: begin
        ctrl_o.build_end = 1'b1;
        state_d          = ST_SCAN_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |-> status_i.out_free) else $error("result loaded over a held beat");

  // Each clear writes the word read in the cycle before.
  a_hit_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.hit_wr |-> $past(ctrl_o.hit_rd)) else $error("clear without a read");

  // Each copied word comes from the read in the cycle before.
  a_copy_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.copy_wr |-> $past(ctrl_o.copy_rd)) else $error("copy without a read");

  // The scan check always follows a scan read.
  a_scan_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.scan_chk |-> $past(ctrl_o.scan_rd)) else $error("scan check without a read");

endmodule

`default_nettype wire

// ===== hw/rtl/segmented_candidate_sieve.sv =====
// Segmented candidate sieve, top level.
// Software drives one command channel and takes candidates from one result
// channel, both valid/ready; a beat moves when valid and ready are high.
// Commands: load prime entry, load base word and restart give no result.
// A next command gives at most one candidate beat.
// A next command in a built segment scans the sieve store one 32-bit word
// at a time from the last position, then loads the result register.
// When a segment is used up the build runs first: it copies the base words
// into the sieve store, then clears the multiples of each prime entry; each
// sieve word is read then written through the single ports of the memories.
// If a freshly built segment has no survivor the command ends with no beat.
// Commands are taken only when the previous one is finished; a waiting
// result is held in the output register, and a later result is not loaded
// until the receiver takes the earlier one.
// Reset clears the pointers, marks a new segment as needed and sets
// segment_bits to its maximum; the memories are not cleared and must be
// loaded before use. Configuration writes are taken at any cycle.
`default_nettype none

module segmented_candidate_sieve import scs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  scs_in_if.sink                     in_ch,
  scs_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_t   ctrl;
  status_t status;

  // Sequencing of commands and segment builds.
  scs_controller u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // Stores, pointers and result register.
  scs_datapath u_dp (
    .clk_i,
    .rst_ni,
    .ctrl_i         (ctrl),
    .status_o       (status),
    .cmd_i          (in_ch.cmd),
    .slot_i         (in_ch.slot),
    .prime_value_i  (in_ch.prime_value),
    .first_offset_i (in_ch.first_offset),
    .pattern_word_i (in_ch.pattern_word),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .candidate_o    (out_ch.candidate)
  );

endmodule

`default_nettype wire
